// ===== design/brush_stroke_dab_interpolator_assert.svh =====
// Assertion macros for the brush stroke dab interpolator.
`ifndef BRUSH_STROKE_DAB_INTERPOLATOR_ASSERT_SVH
`define BRUSH_STROKE_DAB_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSDI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsdi assertion failed");

// Next-cycle implication, checked out of reset.
`define BSDI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsdi assertion failed");

`endif

// ===== design/bsdi_pkg.sv =====
// Shared types and constants of the brush stroke dab interpolator.
package bsdi_pkg;

    localparam int CW            = 12;
    localparam int PW            = 16;
    localparam int RW            = 20;
    localparam int VW            = 21;
    localparam int LW            = 21;
    localparam int SW            = 25;
    localparam int DVW           = 25;
    localparam int DSW           = 7;
    localparam int MAX_DABS_DEF  = 64;
    localparam int unsigned BASE_RADIUS = 1280;
    localparam int unsigned VEL_MAX     = (1 << VW) - 1;
    localparam int unsigned SHORT_LEN   = 256;

    typedef enum logic [1:0] {
        FN_DOWN = 2'd0,
        FN_MOVE = 2'd1,
        FN_UP   = 2'd2,
        FN_NONE = 2'd3
    } func_t;

    typedef enum logic {
        DS_DX = 1'b0,
        DS_DY = 1'b1
    } div_sel_t;

    typedef enum logic [1:0] {
        MD_SINGLE = 2'd0,
        MD_INTERP = 2'd1,
        MD_END    = 2'd2,
        MD_UNUSED = 2'd3
    } mode_t;

    typedef struct packed {
        logic     load;
        logic     sq_x;
        logic     sqrt_start;
        logic     div_start;
        div_sel_t div_sel;
        logic     vel_load;
        logic     rad_load;
        logic     qx_load;
        logic     qy_load;
        logic     emit_init;
        logic     out_load;
    } bsdi_cmd_t;

    typedef struct packed {
        func_t func;
        logic  sqrt_done;
        logic  div_done;
        logic  long_seg;
        logic  dab_last;
        logic  out_free;
    } bsdi_stat_t;

endpackage

// ===== design/bsdi_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bsdi_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bsdi_pkg::DVW-1:0] dividend,
    input  logic [bsdi_pkg::DSW-1:0] divisor,
    output logic [bsdi_pkg::DVW-1:0] quot,
    output logic [bsdi_pkg::DSW-1:0] rem,
    output logic                     done
);
    import bsdi_pkg::*;

    localparam int CNTW = $clog2(DVW + 1);

    logic [DVW-1:0]  quot_reg, quot_next;
    logic [DSW-1:0]  rem_reg, rem_next;
    logic [DSW-1:0]  dsr_reg, dsr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DSW:0]    trial;
    logic            fits;

    assign trial = {rem_reg, quot_reg[DVW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    // Shift one dividend bit into the remainder per step
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNTW'(DVW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DSW'(trial - {1'b0, dsr_reg}) : DSW'(trial);
            quot_next = {quot_reg[DVW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ===== design/bsdi_dp.sv =====
// Datapath: stroke state, squared length, square root, division and dab stepping.
module bsdi_dp
#(
    parameter int MAX_DABS = bsdi_pkg::MAX_DABS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bsdi_pkg::bsdi_cmd_t           cmd,
    output bsdi_pkg::bsdi_stat_t          stat,
    input  logic [1:0]                    in_func,
    input  logic [bsdi_pkg::CW-1:0]       in_x,
    input  logic [bsdi_pkg::CW-1:0]       in_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bsdi_pkg::PW-1:0]       out_x,
    output logic [bsdi_pkg::PW-1:0]       out_y,
    output logic [bsdi_pkg::RW-1:0]       out_radius,
    output logic                          out_end,
    output logic                          out_last
);
    import bsdi_pkg::*;

    localparam int NW   = $clog2(MAX_DABS + 1);
    localparam int OPW  = 42;
    localparam int REMW = LW + 2;
    localparam int SCW  = $clog2(LW + 1);
    // Reciprocals: ceil(2^28 / 10) and ceil(2^24 / 5), exact over the operand ranges
    localparam logic [DVW-1:0] DIV10_MUL = DVW'(26843546);
    localparam int             DIV10_SH  = 28;
    localparam logic [VW:0]    DIV5_MUL  = (VW+1)'(3355444);
    localparam int             DIV5_SH   = 24;

    // Stroke state
    logic [CW-1:0]   prev_x_reg, prev_y_reg, new_x_reg, new_y_reg;
    logic [VW-1:0]   vel_reg;
    logic [RW-1:0]   rad_reg;
    func_t           func_reg;
    mode_t           mode_reg;
    logic [CW-1:0]   dx_reg, dy_reg;
    logic            up_x_reg, up_y_reg;
    logic [SW-1:0]   acc_reg;
    logic [DVW-1:0]  vsum_reg;
    // Square root
    logic [OPW-1:0]  op_reg;
    logic [REMW-1:0] srem_reg;
    logic [LW-1:0]   root_reg;
    logic [SCW-1:0]  scnt_reg;
    logic            sbusy_reg, sdone_reg;
    // Dab stepping
    logic [NW-1:0]   n_reg, i_reg;
    logic [PW-1:0]   qx_reg, qy_reg, offx_reg, offy_reg;
    logic [DSW-1:0]  rx_reg, ry_reg, remx_reg, remy_reg;
    // Output beat
    logic            ovalid_reg;
    logic [PW-1:0]   ox_reg, oy_reg;
    logic [RW-1:0]   orad_reg;
    logic            oend_reg, olast_reg;

    logic [2*CW-1:0] sq;
    logic [CW-1:0]   dxc, dyc, sq_in;
    logic [REMW+1:0] scur, strial;
    logic            sfits;
    logic [LW-9:0]   len_hi;
    logic [NW-1:0]   n_sat;
    logic [DVW-1:0]  div_a, div_q;
    logic [DSW-1:0]  div_b, div_r;
    logic            div_done;
    logic [2*DVW-1:0] vmul;
    logic [DVW-1:0]  vq;
    logic [VW-1:0]   vel_sat;
    logic [2*VW:0]   rmul;
    logic [RW-1:0]   rad_q;
    logic [PW-1:0]   nx16, ny16, dab_x, dab_y;
    logic [DSW:0]    sumx, sumy;
    logic            cy_x, cy_y;
    logic            out_free;

    // Share one multiplier between the two squares
    assign sq_in = cmd.sq_x ? dx_reg : dy_reg;
    assign sq    = sq_in * sq_in;
    assign dxc   = (in_x >= prev_x_reg) ? in_x - prev_x_reg : prev_x_reg - in_x;
    assign dyc   = (in_y >= prev_y_reg) ? in_y - prev_y_reg : prev_y_reg - in_y;

    // Digit-by-digit square root step
    assign scur   = {srem_reg, op_reg[OPW-1 -: 2]};
    assign strial = {2'b00, root_reg, 2'b01};
    assign sfits  = scur >= strial;

    // Dab count from the integer part of the length
    assign len_hi = root_reg[LW-1:8];
    assign n_sat  = (len_hi > (LW-8)'(MAX_DABS)) ? NW'(MAX_DABS) : NW'(len_hi);

    // New velocity: (length + 9 * velocity) / 10 by reciprocal, then saturate
    assign vmul    = vsum_reg * DIV10_MUL;
    assign vq      = DVW'(vmul >> DIV10_SH);
    assign vel_sat = (vq > DVW'(VEL_MAX)) ? VW'(VEL_MAX) : VW'(vq);

    // Radius term: velocity / 5 by reciprocal
    assign rmul  = vel_reg * DIV5_MUL;
    assign rad_q = RW'(rmul >> DIV5_SH);

    // Pick divider operands
    always_comb
    begin
        div_a = '0;
        unique case (cmd.div_sel)
            DS_DX:
            begin
                div_a = DVW'({dx_reg, 4'b0000});
            end
            DS_DY:
            begin
                div_a = DVW'({dy_reg, 4'b0000});
            end
        endcase
        div_b = DSW'(n_reg);
    end

    bsdi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quot     (div_q),
        .rem      (div_r),
        .done     (div_done)
    );

    // Current dab position
    assign nx16  = {new_x_reg, 4'b0000};
    assign ny16  = {new_y_reg, 4'b0000};
    assign dab_x = (mode_reg != MD_INTERP) ? nx16 :
                   (up_x_reg ? nx16 + offx_reg : nx16 - offx_reg);
    assign dab_y = (mode_reg != MD_INTERP) ? ny16 :
                   (up_y_reg ? ny16 + offy_reg : ny16 - offy_reg);
    assign sumx  = {1'b0, remx_reg} + {1'b0, rx_reg};
    assign sumy  = {1'b0, remy_reg} + {1'b0, ry_reg};
    assign cy_x  = sumx >= {1'b0, DSW'(n_reg)};
    assign cy_y  = sumy >= {1'b0, DSW'(n_reg)};
    assign out_free = !ovalid_reg || out_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            vel_reg    <= '0;
            func_reg   <= FN_NONE;
            mode_reg   <= MD_SINGLE;
            sbusy_reg  <= 1'b0;
            sdone_reg  <= 1'b0;
            scnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            sdone_reg <= 1'b0;
            if (cmd.load)
            begin
                func_reg <= func_t'(in_func);
                unique case (func_t'(in_func))
                    FN_DOWN:
                    begin
                        prev_x_reg <= in_x;
                        prev_y_reg <= in_y;
                        vel_reg    <= '0;
                        mode_reg   <= MD_SINGLE;
                    end
                    FN_MOVE:
                    begin
                        prev_x_reg <= in_x;
                        prev_y_reg <= in_y;
                        mode_reg   <= MD_SINGLE;
                    end
                    FN_UP:
                    begin
                        prev_x_reg <= '0;
                        prev_y_reg <= '0;
                        vel_reg    <= '0;
                        mode_reg   <= MD_END;
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
            if (cmd.sqrt_start)
            begin
                sbusy_reg <= 1'b1;
                scnt_reg  <= SCW'(LW);
            end
            else if (sbusy_reg)
            begin
                scnt_reg <= scnt_reg - 1'b1;
                if (scnt_reg == SCW'(1))
                begin
                    sbusy_reg <= 1'b0;
                    sdone_reg <= 1'b1;
                end
            end
            if (cmd.vel_load)
                vel_reg <= vel_sat;
            if (cmd.emit_init)
                mode_reg <= MD_INTERP;
            if (cmd.out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        vsum_reg <= DVW'(root_reg) + DVW'({vel_reg, 3'b000}) + DVW'(vel_reg);
        if (cmd.load)
        begin
            new_x_reg <= in_x;
            new_y_reg <= in_y;
            dx_reg    <= dxc;
            dy_reg    <= dyc;
            up_x_reg  <= prev_x_reg >= in_x;
            up_y_reg  <= prev_y_reg >= in_y;
            rad_reg   <= RW'(BASE_RADIUS);
            i_reg     <= '0;
            n_reg     <= NW'(1);
        end
        if (cmd.sq_x)
            acc_reg <= SW'(sq);
        if (cmd.sqrt_start)
        begin
            op_reg   <= {1'b0, acc_reg + SW'(sq), 16'h0000};
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (sbusy_reg)
        begin
            op_reg   <= {op_reg[OPW-3:0], 2'b00};
            srem_reg <= sfits ? REMW'(scur - strial) : REMW'(scur);
            root_reg <= {root_reg[LW-2:0], sfits};
        end
        if (cmd.rad_load)
        begin
            rad_reg <= RW'(BASE_RADIUS) + rad_q;
            n_reg   <= n_sat;
        end
        if (cmd.qx_load)
        begin
            qx_reg <= PW'(div_q);
            rx_reg <= div_r;
        end
        if (cmd.qy_load)
        begin
            qy_reg <= PW'(div_q);
            ry_reg <= div_r;
        end
        if (cmd.emit_init)
        begin
            offx_reg <= '0;
            offy_reg <= '0;
            remx_reg <= '0;
            remy_reg <= '0;
            i_reg    <= '0;
        end
        else if (cmd.out_load)
        begin
            offx_reg <= offx_reg + qx_reg + PW'(cy_x);
            offy_reg <= offy_reg + qy_reg + PW'(cy_y);
            remx_reg <= cy_x ? DSW'(sumx - {1'b0, DSW'(n_reg)}) : DSW'(sumx);
            remy_reg <= cy_y ? DSW'(sumy - {1'b0, DSW'(n_reg)}) : DSW'(sumy);
            i_reg    <= i_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            ox_reg    <= (mode_reg == MD_END) ? '0 : dab_x;
            oy_reg    <= (mode_reg == MD_END) ? '0 : dab_y;
            orad_reg  <= (mode_reg == MD_END) ? '0 : rad_reg;
            oend_reg  <= mode_reg == MD_END;
            olast_reg <= stat.dab_last;
        end
    end

    assign stat.func      = func_reg;
    assign stat.sqrt_done = sdone_reg;
    assign stat.div_done  = div_done;
    assign stat.long_seg  = root_reg > LW'(SHORT_LEN);
    assign stat.dab_last  = (mode_reg != MD_INTERP) || (i_reg == n_reg - 1'b1);
    assign stat.out_free  = out_free;

    assign out_valid  = ovalid_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_radius = orad_reg;
    assign out_end    = oend_reg;
    assign out_last   = olast_reg;

endmodule

// ===== design/bsdi_ctrl.sv =====
// Controller: sequences one pointer event through the datapath.
module bsdi_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_func,
    input  bsdi_pkg::bsdi_stat_t  stat,
    output bsdi_pkg::bsdi_cmd_t   cmd
);
    import bsdi_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_SQX  = 10'b0000000010,
        ST_SQY  = 10'b0000000100,
        ST_SQRT = 10'b0000001000,
        ST_VEL  = 10'b0000010000,
        ST_RAD  = 10'b0000100000,
        ST_XDIV = 10'b0001000000,
        ST_YDIV = 10'b0010000000,
        ST_QY   = 10'b0100000000,
        ST_EMIT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == ST_IDLE;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DS_DX;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (func_t'(in_func))
                        FN_DOWN: state_next = ST_EMIT;
                        FN_MOVE: state_next = ST_SQX;
                        FN_UP:   state_next = ST_EMIT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                    state_next = ST_VEL;
            end
            ST_VEL:
            begin
                cmd.vel_load = 1'b1;
                state_next   = ST_RAD;
            end
            ST_RAD:
            begin
                cmd.rad_load = 1'b1;
                state_next   = stat.long_seg ? ST_XDIV : ST_EMIT;
            end
            ST_XDIV:
            begin
                // Divisor n was loaded the cycle before
                cmd.div_sel   = DS_DX;
                cmd.div_start = 1'b1;
                state_next    = ST_YDIV;
            end
            ST_YDIV:
            begin
                cmd.div_sel = DS_DY;
                if (stat.div_done)
                begin
                    cmd.qx_load   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_QY;
                end
            end
            ST_QY:
            begin
                if (stat.div_done)
                begin
                    cmd.qy_load   = 1'b1;
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.dab_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/brush_stroke_dab_interpolator.sv =====
// Top level of the brush stroke dab interpolator: controller, datapath and ports.
// Down/up: result beat loaded in ST_EMIT once the output is free, then back to ST_IDLE.
// Move: squares, square root, velocity and radius in turn, then the first dab is loaded
// (a segment over one pixel adds two serial divisions of 25-bit dividends first), then
// one dab per cycle unless the output stalls. Output stalls hold the datapath and the input.
// rst_n (asynchronous, active low) clears position and velocity to zero.
module brush_stroke_dab_interpolator
#(
    parameter int MAX_DABS = bsdi_pkg::MAX_DABS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pos_x [11:0], pos_y [23:12]
    input  logic [1:0]  s_axis_tuser,   // func [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // dab_x [15:0], dab_y [31:16], dab_radius [51:32]
    output logic        m_axis_tuser,   // stroke_end
    output logic        m_axis_tlast    // last_of_run
);
    import bsdi_pkg::*;

    bsdi_cmd_t      cmd;
    bsdi_stat_t     stat;
    logic [PW-1:0]  dab_x, dab_y;
    logic [RW-1:0]  dab_radius;

    bsdi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_func  (s_axis_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsdi_dp #(.MAX_DABS(MAX_DABS)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_axis_tuser),
        .in_x       (s_axis_tdata[CW-1:0]),
        .in_y       (s_axis_tdata[2*CW-1:CW]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_x      (dab_x),
        .out_y      (dab_y),
        .out_radius (dab_radius),
        .out_end    (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, dab_radius, dab_y, dab_x};

    `include "brush_stroke_dab_interpolator_assert.svh"

    `BSDI_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready && s_axis_tuser != FN_NONE, !s_axis_tready)
    `BSDI_ASSERT_NOW(a_end_is_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0 && m_axis_tlast)
    `BSDI_ASSERT_NOW(a_radius_floor, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[51:32] >= 20'd1280)
    `BSDI_ASSERT_NEXT(a_hold_beat, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule
